FILE: sv/cfb_pkg.sv
// Package for the counting fingerprint bucket: sizes, request codes and sequencer states.
// Used by counting_fingerprint_bucket; depends on nothing else.
package cfb_pkg;

   localparam int SLOTS   = 4;
   localparam int FP_BITS = 15;

   localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int OCC_W  = $clog2(SLOTS + 1);
   localparam int SUM_W  = $clog2(SLOTS * 255 + 1);

   localparam logic [7:0] CNT_MAX     = 8'd255;
   localparam int         CNT_OUT_MAX = 1023;
   localparam int         OCC_OUT_MAX = 7;

   typedef enum logic [2:0] {
      REQ_INSERT = 3'd0,
      REQ_REMOVE = 3'd1,
      REQ_COUNT  = 3'd2,
      REQ_EVICT  = 3'd3,
      REQ_PLACE  = 3'd4
   } req_code_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INS_TOP,
      ST_INS_FILL,
      ST_REMOVE,
      ST_COUNT,
      ST_SLOT,
      ST_DONE
   } state_type;

endpackage

FILE: sv/counting_fingerprint_bucket.sv
// Top level of the counting fingerprint bucket: slot store, slot sequencer and result register.
// Depends on cfb_pkg for sizes, request codes and state encoding.
//
//   group  dir  tdata (lowest bit up)                                  tuser
//   req_   in   fingerprint[14:0] count_in[30:15] slot_index[32:31]    req_type[2:0]
//   rsp_   out  remaining[15:0] found[16] fingerprint_out[31:17]       none
//                count_out[41:32] occupied_slots[44:42]
//
// One word is taken at a time. Insert walks the slots twice (top-up, then fill); remove
// and count walk the slots once, remove stopping at its first match; evict and place visit
// only the addressed slot. One slot is visited per cycle by the shared min/subtract and
// compare unit. The synchronous reset empties all slots at once. A finished result waits
// in the output register while the next word is accepted; the sequencer only stalls in
// its last state if that register is still full.
module counting_fingerprint_bucket
   import cfb_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // fingerprint, count_in, slot_index, zero fill
   input  logic [2:0]  req_tuser,   // req_type
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // remaining, found, fingerprint_out, count_out,
                                    // occupied_slots, zero fill
);

   // Slot store. A slot is empty when its count is zero; its fingerprint is then zero too.
   logic [FP_BITS-1:0] slot_fp_ff  [SLOTS];
   logic [7:0]         slot_cnt_ff [SLOTS];

   state_type          state_ff, state_in;
   req_code_type       op_ff;
   logic [SLOT_W-1:0]  idx_ff, idx_in;
   logic               slot_ok_ff;
   logic [FP_BITS-1:0] fp_ff;
   logic [15:0]        copies_ff, copies_in;
   logic [SUM_W-1:0]   sum_ff, sum_in;
   logic               found_ff, found_in;
   logic [FP_BITS-1:0] fpo_ff, fpo_in;
   logic [7:0]         cnto_ff, cnto_in;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic               rsp_valid_ff;
   logic [47:0]        rsp_data_ff;

   logic               accept;
   logic               last_slot;
   logic [FP_BITS-1:0] cur_fp;
   logic [7:0]         cur_cnt;
   logic               cur_match;
   logic [7:0]         limit;
   logic [7:0]         take;
   logic [15:0]        left;
   logic               wr_en;
   logic [FP_BITS-1:0] wr_fp;
   logic [7:0]         wr_cnt;
   logic               out_free;
   logic [9:0]         cnt_field;
   logic [2:0]         occ_field;
   logic [14:0]        req_fp;
   logic [15:0]        req_count;
   logic [1:0]         req_slot;
   req_code_type       req_code;

   assign req_fp    = req_tdata[14:0];
   assign req_count = req_tdata[30:15];
   assign req_slot  = req_tdata[32:31];
   assign req_code  = req_code_type'(req_tuser);

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign last_slot  = (idx_ff == SLOT_W'(SLOTS - 1));

   // The slot under the sequencer's index.
   assign cur_fp    = slot_fp_ff[idx_ff];
   assign cur_cnt   = slot_cnt_ff[idx_ff];
   assign cur_match = (cur_cnt != 8'd0) && (cur_fp == fp_ff);

   // Shared unit: copies that fit under the limit, and what is left over.
   // During the top-up pass the limit is the room left in a matching slot.
   assign limit = (state_ff == ST_INS_TOP) ? (CNT_MAX - cur_cnt) : CNT_MAX;
   assign take  = (copies_ff < {8'd0, limit}) ? copies_ff[7:0] : limit;
   assign left  = copies_ff - {8'd0, take};

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               case (req_code)
                  REQ_INSERT: state_in = ST_INS_TOP;
                  REQ_REMOVE: state_in = ST_REMOVE;
                  REQ_COUNT:  state_in = ST_COUNT;
                  REQ_EVICT:  state_in = ST_SLOT;
                  REQ_PLACE:  state_in = ST_SLOT;
                  default:    state_in = ST_DONE;
               endcase
            end
         end
         ST_INS_TOP:  if (last_slot) state_in = ST_INS_FILL;
         ST_INS_FILL: if (last_slot) state_in = ST_DONE;
         ST_REMOVE:   if (cur_match || last_slot) state_in = ST_DONE;
         ST_COUNT:    if (last_slot) state_in = ST_DONE;
         ST_SLOT:     state_in = ST_DONE;
         ST_DONE:     if (out_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Datapath: slot write, working registers and result fields.
   always_comb begin
      wr_en     = 1'b0;
      wr_fp     = cur_fp;
      wr_cnt    = cur_cnt;
      idx_in    = idx_ff;
      copies_in = copies_ff;
      sum_in    = sum_ff;
      found_in  = found_ff;
      fpo_in    = fpo_ff;
      cnto_in   = cnto_ff;
      occ_in    = occ_ff;
      case (state_ff)
         ST_IDLE: begin
            idx_in = '0;
         end
         ST_INS_TOP: begin
            if (copies_ff != 16'd0 && cur_match && cur_cnt != CNT_MAX) begin
               wr_en     = 1'b1;
               wr_cnt    = cur_cnt + take;
               copies_in = left;
            end
            idx_in = last_slot ? '0 : idx_ff + SLOT_W'(1);
         end
         ST_INS_FILL: begin
            if (copies_ff != 16'd0 && cur_cnt == 8'd0) begin
               wr_en     = 1'b1;
               wr_fp     = fp_ff;
               wr_cnt    = take;
               copies_in = left;
               occ_in    = occ_ff + OCC_W'(1);
            end
            idx_in = idx_ff + SLOT_W'(1);
         end
         ST_REMOVE: begin
            if (cur_match) begin
               wr_en    = 1'b1;
               found_in = 1'b1;
               fpo_in   = cur_fp;
               if (cur_cnt == 8'd1) begin
                  wr_fp  = '0;
                  wr_cnt = 8'd0;
                  occ_in = occ_ff - OCC_W'(1);
               end else begin
                  wr_cnt = cur_cnt - 8'd1;
               end
            end
            idx_in = idx_ff + SLOT_W'(1);
         end
         ST_COUNT: begin
            if (cur_match) sum_in = sum_ff + SUM_W'(cur_cnt);
            idx_in = idx_ff + SLOT_W'(1);
         end
         ST_SLOT: begin
            if (slot_ok_ff) begin
               wr_en = 1'b1;
               if (op_ff == REQ_EVICT) begin
                  fpo_in  = cur_fp;
                  cnto_in = cur_cnt;
                  wr_fp   = '0;
                  wr_cnt  = 8'd0;
                  if (cur_cnt != 8'd0) occ_in = occ_ff - OCC_W'(1);
               end else begin
                  wr_cnt    = take;
                  wr_fp     = (take != 8'd0) ? fp_ff : '0;
                  copies_in = left;
                  if (cur_cnt == 8'd0 && take != 8'd0) occ_in = occ_ff + OCC_W'(1);
                  if (cur_cnt != 8'd0 && take == 8'd0) occ_in = occ_ff - OCC_W'(1);
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Count field: a query's sum, or the evicted slot's count; saturated to ten bits.
   always_comb begin
      if (op_ff == REQ_COUNT) begin
         cnt_field = (32'(sum_ff) > CNT_OUT_MAX) ? 10'(CNT_OUT_MAX) : 10'(sum_ff);
      end else begin
         cnt_field = {2'd0, cnto_ff};
      end
      occ_field = (32'(occ_ff) > OCC_OUT_MAX) ? 3'(OCC_OUT_MAX) : 3'(occ_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < SLOTS; i++) begin
            slot_fp_ff[i]  <= '0;
            slot_cnt_ff[i] <= 8'd0;
         end
      end else begin
         state_ff <= state_in;
         occ_ff   <= occ_in;
         if (wr_en) begin
            slot_fp_ff[idx_ff]  <= wr_fp;
            slot_cnt_ff[idx_ff] <= wr_cnt;
         end
         if (state_ff == ST_DONE && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Working registers and the result word carry no reset.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff      <= req_code;
         fp_ff      <= FP_BITS'(req_fp);
         copies_ff  <= (req_code == REQ_INSERT || req_code == REQ_PLACE) ? req_count : 16'd0;
         idx_ff     <= (req_code == REQ_EVICT || req_code == REQ_PLACE) ?
                       SLOT_W'(req_slot) : '0;
         slot_ok_ff <= (32'(req_slot) < SLOTS);
         sum_ff     <= '0;
         found_ff   <= 1'b0;
         fpo_ff     <= '0;
         cnto_ff    <= 8'd0;
      end else begin
         idx_ff    <= idx_in;
         copies_ff <= copies_in;
         sum_ff    <= sum_in;
         found_ff  <= found_in;
         fpo_ff    <= fpo_in;
         cnto_ff   <= cnto_in;
      end
      if (state_ff == ST_DONE && out_free) begin
         rsp_data_ff <= {3'd0, occ_field, cnt_field, 15'(fpo_ff), found_ff, copies_ff};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on the slot store and the sequencer.
   logic [SLOTS-1:0] slot_busy;
   logic [SLOTS-1:0] stray_fp;

   always_comb begin
      for (int i = 0; i < SLOTS; i++) begin
         slot_busy[i] = (slot_cnt_ff[i] != 8'd0);
         stray_fp[i]  = (slot_cnt_ff[i] == 8'd0) && (slot_fp_ff[i] != '0);
      end
   end

   a_occ_tracks_store: assert property (@(posedge clock) disable iff (reset)
      32'(occ_ff) == $countones(slot_busy))
      else $error("occupancy counter disagrees with the slot store");

   a_empty_slot_clean: assert property (@(posedge clock) disable iff (reset)
      stray_fp == '0)
      else $error("an empty slot holds a nonzero fingerprint");

   a_accept_starts_work: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff != ST_IDLE)
      else $error("an accepted word did not start the sequencer");

endmodule
